FILE: hdl/dnts_pkg.sv
// Package for the decimal number text scanner.
// Character codes, scan phases, status codes, register indexes and reset values.
// Depends on nothing; every other file but char_stream_if imports it.
`default_nettype none

package dnts_pkg;

  localparam int EXP_WIDTH_DEF = 32;
  localparam int EXP_OUT_W     = 32;
  localparam int MANT_W        = 60;
  localparam int SIG_W         = 5;
  localparam int UFL_W         = 10;
  localparam int OFL_W         = 9;
  localparam int CFG_DATA_W    = 10;
  localparam int CFG_IDX_W     = 2;

  localparam logic [SIG_W-1:0] MAX_DIGITS = 5'd18;

  localparam logic [SIG_W-1:0]        SIG_DIGITS_RST      = 5'd18;
  localparam logic signed [UFL_W-1:0] UNDERFLOW_LIMIT_RST = -10'sd328;
  localparam logic [OFL_W-1:0]        OVERFLOW_LIMIT_RST  = 9'd309;

  localparam logic [CFG_IDX_W-1:0] REG_SIG_DIGITS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNDERFLOW_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW_LIMIT  = 2'd2;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_E_LO  = 8'h65;

  typedef enum logic [3:0] {
    PH_SPACE,
    PH_SIGN,
    PH_LEADZ,
    PH_FRACZ,
    PH_INT,
    PH_FRAC,
    PH_ESIGN,
    PH_EZERO,
    PH_EDIG,
    PH_STOP
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_PLUS_ZERO,
    ST_MINUS_ZERO,
    ST_PLUS_INF,
    ST_MINUS_INF
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/char_stream_if.sv
// Character request channel: one text byte and an end-of-text mark.
// Uses no package items.
`default_nettype none

interface char_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/number_stream_if.sv
// Result request channel: sign, mantissa, decimal exponent and status.
// Mantissa and exponent widths come from dnts_pkg.
`default_nettype none

interface number_stream_if;
  import dnts_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        negative;
  logic [MANT_W-1:0]           mantissa;
  logic signed [EXP_OUT_W-1:0] exponent;
  logic [2:0]                  status;

  modport source (output valid, output negative, output mantissa, output exponent,
                  output status, input ready);
  modport sink   (input valid, input negative, input mantissa, input exponent,
                  input status, output ready);
endinterface

`default_nettype wire

FILE: hdl/dnts_scan.sv
// Character scanner: input register, scan phase and accumulators, one character a cycle
// unless a final byte waits. Hands each scan to dnts_final; uses dnts_pkg, char_stream_if.
`default_nettype none

module dnts_scan import dnts_pkg::*; #(
  parameter int EXP_WIDTH = EXP_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  char_stream_if.sink                      text,
  input  wire logic [SIG_W-1:0]            sig_digits,
  output logic                             snap_valid,
  input  wire logic                        snap_ready,
  output logic                             snap_negative,
  output logic [MANT_W-1:0]                snap_mantissa,
  output logic signed [EXP_WIDTH-1:0]      snap_dec_exp,
  output logic                             snap_exp_negative,
  output logic [EXP_WIDTH-2:0]             snap_exp_acc
);

  localparam logic signed [EXP_WIDTH-1:0] DEXP_MAX = {1'b0, {(EXP_WIDTH-1){1'b1}}};
  localparam logic signed [EXP_WIDTH-1:0] DEXP_MIN =
    {1'b1, {(EXP_WIDTH-2){1'b0}}, 1'b1};
  localparam logic signed [EXP_WIDTH-1:0] DEXP_ONE = {{(EXP_WIDTH-1){1'b0}}, 1'b1};
  localparam logic [EXP_WIDTH-2:0] EACC_MAX = '1;
  localparam int EP_W = EXP_WIDTH + 3;

  logic       in_valid;
  logic [7:0] in_ch;
  logic       in_last;
  logic       go;

  phase_t                      phase, phase_next;
  logic                        sign_flag, sign_flag_next;
  logic [MANT_W-1:0]           mant_acc, mant_acc_next;
  logic [SIG_W-1:0]            digit_count, digit_count_next;
  logic signed [EXP_WIDTH-1:0] dec_exp, dec_exp_next;
  logic                        exp_negative, exp_negative_next;
  logic [EXP_WIDTH-2:0]        exp_acc, exp_acc_next;

  logic              is_ws, is_dig, is_zero, is_dot, is_plus, is_minus, is_e;
  logic [3:0]        dval;
  logic [SIG_W-1:0]  kept_limit;
  logic              take;
  logic [MANT_W-1:0] mant_mul;
  logic [EP_W-1:0]   eacc_ext, eacc_mul;
  logic signed [EXP_WIDTH-1:0] dexp_inc, dexp_dec;
  phase_t            p;

  assign go         = in_valid && (!in_last || !snap_valid || snap_ready);
  assign text.ready = !in_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
    if (text.valid && text.ready) begin
      in_ch   <= text.ch;
      in_last <= text.last;
    end
  end

  assign is_ws    = (in_ch >= CH_TAB && in_ch <= CH_CR) || in_ch == CH_SPACE;
  assign is_dig   = in_ch >= CH_ZERO && in_ch <= CH_NINE;
  assign is_zero  = in_ch == CH_ZERO;
  assign is_dot   = in_ch == CH_DOT;
  assign is_plus  = in_ch == CH_PLUS;
  assign is_minus = in_ch == CH_MINUS;
  assign is_e     = in_ch == CH_E_UP || in_ch == CH_E_LO;
  assign dval     = in_ch[3:0];

  assign kept_limit = (sig_digits > MAX_DIGITS) ? MAX_DIGITS : sig_digits;
  assign take       = digit_count < kept_limit;

  assign mant_mul = {mant_acc[MANT_W-4:0], 3'b000} + {mant_acc[MANT_W-2:0], 1'b0}
                    + MANT_W'(dval);
  assign eacc_ext = EP_W'(exp_acc);
  assign eacc_mul = (eacc_ext << 3) + (eacc_ext << 1) + EP_W'(dval);
  assign dexp_inc = (dec_exp == DEXP_MAX) ? DEXP_MAX : dec_exp + DEXP_ONE;
  assign dexp_dec = (dec_exp == DEXP_MIN) ? DEXP_MIN : dec_exp - DEXP_ONE;

  // phases that pass the character on without using it
  always_comb begin
    p = phase;
    if (p == PH_SPACE && !is_ws) p = PH_SIGN;
    if (p == PH_SIGN && !is_plus && !is_minus) p = (is_dig || is_dot) ? PH_LEADZ : PH_STOP;
    if (p == PH_LEADZ && !is_zero && !is_dot) p = PH_INT;
    if (p == PH_INT && !is_dig && !is_dot) p = PH_FRAC;
    if (p == PH_FRACZ && !is_zero) p = PH_FRAC;
    if (p == PH_FRAC && !is_dig && !is_e) p = PH_STOP;
    if (p == PH_ESIGN && !is_plus && !is_minus) p = PH_EZERO;
    if (p == PH_EZERO && !is_zero) p = PH_EDIG;
    if (p == PH_EDIG && !is_dig) p = PH_STOP;
  end

  always_comb begin
    phase_next        = p;
    sign_flag_next    = sign_flag;
    mant_acc_next     = mant_acc;
    digit_count_next  = digit_count;
    dec_exp_next      = dec_exp;
    exp_negative_next = exp_negative;
    exp_acc_next      = exp_acc;
    unique case (p)
      PH_SIGN: begin
        phase_next = PH_LEADZ;
        if (is_minus) sign_flag_next = 1'b1;
      end
      PH_LEADZ: begin
        if (is_dot) phase_next = PH_FRACZ;
      end
      PH_INT: begin
        if (is_dig) begin
          if (take) begin
            mant_acc_next    = mant_mul;
            digit_count_next = digit_count + 1'b1;
          end else begin
            dec_exp_next = dexp_inc;
          end
        end else begin
          phase_next = PH_FRAC;
        end
      end
      PH_FRACZ: begin
        dec_exp_next = dexp_dec;
      end
      PH_FRAC: begin
        if (is_dig) begin
          if (take) begin
            mant_acc_next    = mant_mul;
            digit_count_next = digit_count + 1'b1;
            dec_exp_next     = dexp_dec;
          end
        end else begin
          phase_next = PH_ESIGN;
        end
      end
      PH_ESIGN: begin
        phase_next = PH_EZERO;
        if (is_minus) exp_negative_next = 1'b1;
      end
      PH_EDIG: begin
        exp_acc_next = (eacc_mul > EP_W'(EACC_MAX)) ? EACC_MAX : eacc_mul[EXP_WIDTH-2:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SPACE;
      sign_flag    <= 1'b0;
      mant_acc     <= '0;
      digit_count  <= '0;
      dec_exp      <= '0;
      exp_negative <= 1'b0;
      exp_acc      <= '0;
      snap_valid   <= 1'b0;
    end else begin
      snap_valid <= (go && in_last) || (snap_valid && !snap_ready);
      if (go) begin
        if (in_last) begin
          phase        <= PH_SPACE;
          sign_flag    <= 1'b0;
          mant_acc     <= '0;
          digit_count  <= '0;
          dec_exp      <= '0;
          exp_negative <= 1'b0;
          exp_acc      <= '0;
        end else begin
          phase        <= phase_next;
          sign_flag    <= sign_flag_next;
          mant_acc     <= mant_acc_next;
          digit_count  <= digit_count_next;
          dec_exp      <= dec_exp_next;
          exp_negative <= exp_negative_next;
          exp_acc      <= exp_acc_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && in_last) begin
      snap_negative     <= sign_flag_next;
      snap_mantissa     <= mant_acc_next;
      snap_dec_exp      <= dec_exp_next;
      snap_exp_negative <= exp_negative_next;
      snap_exp_acc      <= exp_acc_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dnts_final.sv
// Finishing stage: combines the decimal exponents, saturates, classifies, registers the result.
// Uses dnts_pkg and number_stream_if.
`default_nettype none

module dnts_final import dnts_pkg::*; #(
  parameter int EXP_WIDTH = EXP_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           snap_valid,
  output logic                                snap_ready,
  input  wire logic                           snap_negative,
  input  wire logic [MANT_W-1:0]              snap_mantissa,
  input  wire logic signed [EXP_WIDTH-1:0]    snap_dec_exp,
  input  wire logic                           snap_exp_negative,
  input  wire logic [EXP_WIDTH-2:0]           snap_exp_acc,
  input  wire logic signed [UFL_W-1:0]        underflow_limit,
  input  wire logic [OFL_W-1:0]               overflow_limit,
  number_stream_if.source                     number
);

  localparam logic signed [EXP_WIDTH:0] SUM_MAX = {2'b00, {(EXP_WIDTH-1){1'b1}}};
  localparam logic signed [EXP_WIDTH:0] SUM_MIN = {2'b11, {(EXP_WIDTH-2){1'b0}}, 1'b1};

  logic                        take;
  logic signed [EXP_WIDTH:0]   dexp_ext, eacc_ext, sum, uf_ext, of_ext;
  logic signed [EXP_WIDTH-1:0] e_sat;
  logic                        is_zero, is_inf;
  status_t                     status_next;

  assign snap_ready = !number.valid || number.ready;
  assign take       = snap_valid && snap_ready;

  assign dexp_ext = {snap_dec_exp[EXP_WIDTH-1], snap_dec_exp};
  assign eacc_ext = {2'b00, snap_exp_acc};
  assign sum      = snap_exp_negative ? dexp_ext - eacc_ext : dexp_ext + eacc_ext;
  assign uf_ext   = (EXP_WIDTH+1)'(underflow_limit);
  assign of_ext   = {{(EXP_WIDTH+1-OFL_W){1'b0}}, overflow_limit};

  // limits are far inside the saturation range, so compare before saturating
  assign e_sat   = (sum > SUM_MAX) ? SUM_MAX[EXP_WIDTH-1:0] :
                   (sum < SUM_MIN) ? SUM_MIN[EXP_WIDTH-1:0] : sum[EXP_WIDTH-1:0];
  assign is_zero = (snap_mantissa == '0) || (sum < uf_ext);
  assign is_inf  = sum > of_ext;

  always_comb begin
    if (is_zero) begin
      status_next = snap_negative ? ST_MINUS_ZERO : ST_PLUS_ZERO;
    end else if (is_inf) begin
      status_next = snap_negative ? ST_MINUS_INF : ST_PLUS_INF;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number.valid <= 1'b0;
    end else if (snap_ready) begin
      number.valid <= snap_valid;
    end
    if (take) begin
      number.negative <= snap_negative;
      number.mantissa <= snap_mantissa;
      number.exponent <= EXP_OUT_W'(e_sat);
      number.status   <= status_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/decimal_number_text_scanner.sv
// Decimal number text scanner, top level: configuration registers, scanner, finishing stage.
// Uses dnts_pkg, char_stream_if, number_stream_if, dnts_scan, dnts_final.
//
// Text enters on "text", one byte per request, with last set on the final byte.
// Leading white space, sign, integer and fraction digits and an e/E exponent are
// scanned; bytes after the scan stops are dropped until last. Each last byte gives
// one request on "number": sign, kept mantissa, decimal exponent and status.
// Throughput: one character per cycle, set by the single scan stage, except that a final
// byte waits while a finished result is buffered. After acceptance, the last byte passes
// the input register, the snapshot and the output register before the result is valid.
// Configuration (cfg_en/cfg_index/cfg_data) is to be written by the user between numbers
// while idle, which the block itself does not enforce; unknown indexes are ignored.
// Reset restores sig_digits 18, underflow_limit -328, overflow_limit 309 and clears
// the scan. When "number" stalls, the result holds and one more finished result is
// buffered; non-final bytes keep flowing, and a final byte then waits in the input
// register with text.ready low.
`default_nettype none

module decimal_number_text_scanner import dnts_pkg::*; #(
  parameter int EXP_WIDTH = EXP_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  char_stream_if.sink                text,
  number_stream_if.source            number,
  input  wire logic                  cfg_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [SIG_W-1:0]        sig_digits;
  logic signed [UFL_W-1:0] underflow_limit;
  logic [OFL_W-1:0]        overflow_limit;

  logic                        snap_valid, snap_ready, snap_negative, snap_exp_negative;
  logic [MANT_W-1:0]           snap_mantissa;
  logic signed [EXP_WIDTH-1:0] snap_dec_exp;
  logic [EXP_WIDTH-2:0]        snap_exp_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      sig_digits      <= SIG_DIGITS_RST;
      underflow_limit <= UNDERFLOW_LIMIT_RST;
      overflow_limit  <= OVERFLOW_LIMIT_RST;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_SIG_DIGITS:      sig_digits      <= cfg_data[SIG_W-1:0];
        REG_UNDERFLOW_LIMIT: underflow_limit <= cfg_data[UFL_W-1:0];
        REG_OVERFLOW_LIMIT:  overflow_limit  <= cfg_data[OFL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dnts_scan #(.EXP_WIDTH(EXP_WIDTH)) u_scan (
    .clk               (clk),
    .rst               (rst),
    .text              (text),
    .sig_digits        (sig_digits),
    .snap_valid        (snap_valid),
    .snap_ready        (snap_ready),
    .snap_negative     (snap_negative),
    .snap_mantissa     (snap_mantissa),
    .snap_dec_exp      (snap_dec_exp),
    .snap_exp_negative (snap_exp_negative),
    .snap_exp_acc      (snap_exp_acc)
  );

  dnts_final #(.EXP_WIDTH(EXP_WIDTH)) u_final (
    .clk               (clk),
    .rst               (rst),
    .snap_valid        (snap_valid),
    .snap_ready        (snap_ready),
    .snap_negative     (snap_negative),
    .snap_mantissa     (snap_mantissa),
    .snap_dec_exp      (snap_dec_exp),
    .snap_exp_negative (snap_exp_negative),
    .snap_exp_acc      (snap_exp_acc),
    .underflow_limit   (underflow_limit),
    .overflow_limit    (overflow_limit),
    .number            (number)
  );

endmodule

`default_nettype wire
